// ----- src/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg: shared types for the sliding window median filter
// Holds the configuration width, the reset window length, the sequencer state
// encoding and the command word that starts a merge pass in the sorted store.
// ----------------------------------------------------------------------------
package swm_pkg;

    // configuration register width and reset value
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] WIN_LEN_RESET = 5'd16;

    // top level sequencer, one-hot
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MERGE = 3'b010,
        S_FIN   = 3'b100
    } swm_state_t;

    // command from the sequencer to the sorted store
    typedef struct packed {
        logic start;    // begin a merge pass with a new word
        logic replace;  // window full: drop the oldest entry during the pass
        logic bank;     // bank that holds the current sorted window
    } swm_cmd_t;

endpackage

// ----- src/swm_store.sv -----
// ----------------------------------------------------------------------------
// swm_store: ping-pong sorted store with a shared compare and write unit
// One pass reads the sorted window from one bank, one entry a cycle save for the insert,
// drops a full window's oldest entry, merges the new sample in, writes the other bank.
// ----------------------------------------------------------------------------
module swm_store #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swm_pkg::swm_cmd_t                  cmd,
    input  logic [SAMPLE_BITS-1:0]             sample,
    input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] new_stamp,
    input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] oldest_stamp,
    input  logic [$clog2(MAX_WINDOW + 1)-1:0]  held_old,
    input  logic [$clog2(MAX_WINDOW + 1)-1:0]  mid,
    output logic                               done,
    output logic [SAMPLE_BITS-1:0]             median
);
    import swm_pkg::*;

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int ENT_W = SAMPLE_BITS + IDX_W;

    // entry: {sample, stamp}
    logic [ENT_W-1:0] mem0 [MAX_WINDOW];
    logic [ENT_W-1:0] mem1 [MAX_WINDOW];
    logic [ENT_W-1:0] rd0_reg;
    logic [ENT_W-1:0] rd1_reg;

    logic                   active_reg;
    logic                   replace_reg;
    logic                   bank_reg;
    logic [SAMPLE_BITS-1:0] s_reg;
    logic [IDX_W-1:0]       new_stamp_reg;
    logic [IDX_W-1:0]       oldest_reg;
    logic [CNT_W-1:0]       held_old_reg;
    logic [CNT_W-1:0]       mid_reg;
    logic [CNT_W-1:0]       head_idx_reg;
    logic [CNT_W-1:0]       head_idx_next;
    logic                   rvalid_reg;
    logic                   rvalid_next;
    logic                   ins_done_reg;
    logic                   ins_done_next;
    logic [CNT_W-1:0]       wr_idx_reg;
    logic                   skip_seen_reg;
    logic [SAMPLE_BITS-1:0] median_reg;

    logic [ENT_W-1:0]       head;
    logic [SAMPLE_BITS-1:0] head_val;
    logic [IDX_W-1:0]       head_stamp;
    logic                   is_oldest;
    logic                   s_first;
    logic                   consume;
    logic                   wr_en;
    logic [ENT_W-1:0]       wr_data;
    logic                   fin;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;

    assign head       = bank_reg ? rd1_reg : rd0_reg;
    assign head_val   = head[ENT_W-1:IDX_W];
    assign head_stamp = head[IDX_W-1:0];
    assign is_oldest  = rvalid_reg && replace_reg && (head_stamp == oldest_reg);
    assign s_first    = !ins_done_reg &&
                        (!rvalid_reg || ($signed(s_reg) <= $signed(head_val)));

    // shared merge step: skip oldest, emit new sample, emit head, or finish the pass
    always_comb
    begin
        consume       = 1'b0;
        wr_en         = 1'b0;
        wr_data       = head;
        ins_done_next = ins_done_reg;
        fin           = 1'b0;
        if (active_reg)
        begin
            if (is_oldest)
            begin
                consume = 1'b1;
            end
            else if (s_first)
            begin
                wr_en         = 1'b1;
                wr_data       = {s_reg, new_stamp_reg};
                ins_done_next = 1'b1;
            end
            else if (rvalid_reg)
            begin
                wr_en   = 1'b1;
                consume = 1'b1;
            end
            else
            begin
                fin = 1'b1;
            end
        end
    end

    // read pointer: re-read the head when it was not consumed
    always_comb
    begin
        if (cmd.start)
        begin
            head_idx_next = '0;
            rvalid_next   = (held_old != '0);
        end
        else if (consume)
        begin
            head_idx_next = head_idx_reg + CNT_W'(1);
            rvalid_next   = (head_idx_next < held_old_reg);
        end
        else
        begin
            head_idx_next = head_idx_reg;
            rvalid_next   = rvalid_reg;
        end
    end

    assign rd_addr = head_idx_next[IDX_W-1:0];
    assign wr_addr = wr_idx_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en && bank_reg)
        begin
            mem0[wr_addr] <= wr_data;
        end
        if (wr_en && !bank_reg)
        begin
            mem1[wr_addr] <= wr_data;
        end
        rd0_reg <= mem0[rd_addr];
        rd1_reg <= mem1[rd_addr];
    end

    // payload latched at pass start
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            s_reg         <= sample;
            new_stamp_reg <= new_stamp;
            oldest_reg    <= oldest_stamp;
            held_old_reg  <= held_old;
            mid_reg       <= mid;
        end
        if (wr_en && (wr_idx_reg == mid_reg))
        begin
            median_reg <= wr_data[ENT_W-1:IDX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            replace_reg   <= 1'b0;
            bank_reg      <= 1'b0;
            head_idx_reg  <= '0;
            rvalid_reg    <= 1'b0;
            ins_done_reg  <= 1'b0;
            wr_idx_reg    <= '0;
            skip_seen_reg <= 1'b0;
        end
        else
        begin
            head_idx_reg <= head_idx_next;
            rvalid_reg   <= rvalid_next;
            if (cmd.start)
            begin
                active_reg    <= 1'b1;
                replace_reg   <= cmd.replace;
                bank_reg      <= cmd.bank;
                ins_done_reg  <= 1'b0;
                wr_idx_reg    <= '0;
                skip_seen_reg <= 1'b0;
            end
            else if (active_reg)
            begin
                ins_done_reg <= ins_done_next;
                if (wr_en)
                begin
                    wr_idx_reg <= wr_idx_reg + CNT_W'(1);
                end
                if (is_oldest)
                begin
                    skip_seen_reg <= 1'b1;
                end
                if (fin)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    assign done   = fin;
    assign median = median_reg;

    // head pointer stays inside the old window
    a_head_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> (head_idx_reg < held_old_reg))
        else $error("store head read past old window");

    // at most one more entry than before is written
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_idx_reg <= held_old_reg))
        else $error("store write past new window");

    // a full window must have dropped its oldest entry by pass end
    a_oldest_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && replace_reg) |-> skip_seen_reg)
        else $error("oldest entry not found during merge");

    // the median slot was written before the pass ends
    a_median_seen: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> (wr_idx_reg > mid_reg))
        else $error("median slot not written");

endmodule

// ----- src/sliding_window_median.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median: running median over a sorted sliding window
// Keeps the last window_length samples sorted with an insertion stamp per
// entry and returns the middle element and the fill count for every word.
// ----------------------------------------------------------------------------
// an accepted word runs a merge pass through the store (S_MERGE), waits in
//   S_FIN until the output register is free or draining, and is registered there
// no new word is taken until the last result is in the output register; the merge
//   pass reads the store one entry a cycle, save for the insert, via one compare unit
// reset: sequencer idle, fill count, stamps and output valid cleared, window_length
//   set to 16; store contents are undefined and only read after being written
module sliding_window_median #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [SAMPLE_BITS-1:0]            sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [SAMPLE_BITS-1:0]            median,
    output logic [$clog2(MAX_WINDOW + 1)-1:0] fill_count
);
    import swm_pkg::*;

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    swm_state_t             state_reg;
    swm_state_t             state_next;
    logic [CFG_W-1:0]       win_len_reg;
    logic [CNT_W-1:0]       held_reg;
    logic [IDX_W-1:0]       stamp_reg;
    logic                   bank_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] median_out_reg;
    logic [CNT_W-1:0]       fill_out_reg;

    logic                   accept;
    logic                   at_max;
    logic                   full;
    logic [CNT_W-1:0]       held_new;
    logic                   load_out;
    swm_cmd_t               cmd;
    logic                   st_done;
    logic [SAMPLE_BITS-1:0] st_median;

    // one word in flight; the output register lets the next word enter
    // while a finished result still waits downstream
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    // effective window: zero acts as one, anything above the store depth
    // is clipped to it; the fill count never shrinks
    assign at_max = (held_reg == CNT_W'(MAX_WINDOW));
    assign full   = at_max ||
                    ((win_len_reg == '0) ? (held_reg != '0)
                                         : (CMP_W'(held_reg) >= CMP_W'(win_len_reg)));
    assign held_new = full ? held_reg : (held_reg + CNT_W'(1));

    assign cmd.start   = accept;
    assign cmd.replace = full;
    assign cmd.bank    = bank_reg;

    // stamps count words mod 2**IDX_W (the store depth, rounded up to a power of
    // two); the oldest entry carries the stamp that lies held_reg words back
    swm_store #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample       (sample),
        .new_stamp    (stamp_reg),
        .oldest_stamp (stamp_reg - IDX_W'(held_reg)),
        .held_old     (held_reg),
        .mid          (held_new >> 1),
        .done         (st_done),
        .median       (st_median)
    );

    // result moves to the output register once it is free or draining
    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                if (st_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_len_reg   <= WIN_LEN_RESET;
            held_reg      <= '0;
            stamp_reg     <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                win_len_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                held_reg  <= held_new;
                stamp_reg <= stamp_reg + IDX_W'(1);
            end
            // the freshly written bank becomes the current window
            if (st_done)
            begin
                bank_reg <= ~bank_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            median_out_reg <= st_median;
            fill_out_reg   <= held_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign median     = median_out_reg;
    assign fill_count = fill_out_reg;

    // the store only finishes a pass that the sequencer started
    a_done_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
        st_done |-> (state_reg == S_MERGE))
        else $error("merge done outside merge state");

    // fill count never drops
    a_held_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (held_reg >= $past(held_reg)))
        else $error("fill count decreased");

    // every result reports a legal fill count
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((fill_out_reg != '0) && (fill_out_reg <= CNT_W'(MAX_WINDOW))))
        else $error("fill count out of range");

    // fill count never exceeds the store depth
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((held_reg != '0) && (held_reg <= CNT_W'(MAX_WINDOW))))
        else $error("fill count exceeds store depth");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sliding_window_median
// Drives signed samples through the valid/stall input channel, predicts the
// sorted window and its middle element for every accepted word, and checks
// median and fill count on each result word in order. The window length is
// stepped through several values, including out-of-range and shrinking ones,
// with both channels idling at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_WIN   = 16;
    localparam int WDOG_MAX  = 5000;    // cycles without any handshake
    localparam int IDLE_PCT  = 10;      // idle / stall chance per cycle
    localparam int QUIET_LO  = 300;     // no idling for words in this span
    localparam int QUIET_HI  = 420;

    // one result word as the block returns it
    typedef struct packed {
        logic [15:0] median;
        logic [4:0]  fill_count;
    } median_word_t;

    // dut ports, inputs known from time zero
    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [swm_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic [15:0]               sample      = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic [15:0]               median;
    logic [4:0]                fill_count;

    // samples waiting to be sent, and results still owed by the block
    logic [15:0]  pending_samples[$];
    median_word_t expected_medians[$];

    // shadow of the filter state: sorted window, age per entry, fill level
    logic signed [15:0] window_store[MAX_WIN];
    int                 window_ages[MAX_WIN];
    int                 window_held  = 0;
    int                 window_limit = int'(swm_pkg::WIN_LEN_RESET);

    int fail_count     = 0;
    int sent_count     = 0;
    int received_count = 0;
    int stuck_cycles   = 0;

    always #1 clk = ~clk;

    sliding_window_median u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .median      (median),
        .fill_count  (fill_count)
    );

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    // insert one sample into the shadow window and return the result word
    task automatic insert_sample(input logic signed [15:0] s, output median_word_t res);
        int  eff;
        int  pos;
        int  mid;
        bit  found;
        eff = window_limit;
        if (eff < 1)
            eff = 1;
        if (eff > MAX_WIN)
            eff = MAX_WIN;
        pos = 0;
        if (window_held < eff)
        begin
            // still filling: take the next free slot
            pos = window_held;
            window_held++;
        end
        else
        begin
            // full (or shrunk): overwrite the oldest entry, slot 0 as fallback
            found = 1'b0;
            for (int i = 0; i < window_held && !found; i++)
                if (window_ages[i] == window_held - 1)
                begin
                    pos   = i;
                    found = 1'b1;
                end
        end
        for (int i = 0; i < window_held; i++)
            window_ages[i]++;
        window_store[pos] = s;
        window_ages[pos]  = 0;
        // bubble up, then down, strict compares so equal values stay put
        while (pos + 1 < window_held && s > window_store[pos+1])
        begin
            window_store[pos]   = window_store[pos+1];
            window_ages[pos]    = window_ages[pos+1];
            window_store[pos+1] = s;
            window_ages[pos+1]  = 0;
            pos++;
        end
        while (pos > 0 && s < window_store[pos-1])
        begin
            window_store[pos]   = window_store[pos-1];
            window_ages[pos]    = window_ages[pos-1];
            window_store[pos-1] = s;
            window_ages[pos-1]  = 0;
            pos--;
        end
        mid = window_held / 2;
        if (mid >= MAX_WIN)
            mid = MAX_WIN - 1;
        res.median     = window_store[mid];
        res.fill_count = window_held[4:0];
    endtask

    // mix of wide values, narrow clusters that force ties, and the extremes
    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom);
            4, 5, 6:    return 16'($signed($urandom_range(0, 16)) - 8);
            7:          return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default:    return 16'($urandom_range(0, 3) * 1000);
        endcase
    endfunction

    // wait until nothing is queued, in flight or owed
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_medians.size() != 0);
    endtask

    // window length changes only while the block is idle
    task automatic write_window_length(input logic [swm_pkg::CFG_W-1:0] len);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= len;
        window_limit = int'(len);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            pending_samples.push_back(random_sample());
    endtask

    // ------------------------------------------------------------------------
    // driver: presents queued samples, runs the predictor on each handshake
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_samples
        median_word_t res;
        bit           quiet;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                insert_sample($signed(sample), res);
                expected_medians.push_back(res);
                sent_count++;
            end
            quiet = sent_count >= QUIET_LO && sent_count < QUIET_HI;
            // a stalled word stays put; otherwise pick the next one or idle
            if (!in_valid || !in_stall)
            begin
                if (pending_samples.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    sample   <= pending_samples.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back pressure, compares each result with the oldest
    // expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        median_word_t want;
        bit           quiet;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                received_count++;
                if (expected_medians.size() == 0)
                    report_mismatch($sformatf("unexpected word median %0d fill %0d",
                                              $signed(median), fill_count));
                else
                begin
                    want = expected_medians.pop_front();
                    if (median !== want.median)
                        report_mismatch($sformatf("word %0d median %0d, want %0d",
                                                  received_count, $signed(median),
                                                  $signed(want.median)));
                    if (fill_count !== want.fill_count)
                        report_mismatch($sformatf("word %0d fill %0d, want %0d",
                                                  received_count, fill_count,
                                                  want.fill_count));
                end
            end
            quiet = received_count >= QUIET_LO && received_count < QUIET_HI;
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog: too long with no handshake on either side means a hang
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WDOG_MAX)
        begin
            $display("timeout after %0d idle cycles", stuck_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence: reset, then phases of window length and samples
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero acts as a one-entry window
        write_window_length(5'd0);
        pending_samples.push_back(16'h7fff);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h0000);

        // one entry, every word replaces the only one held
        write_window_length(5'd1);
        pending_samples.push_back(16'hffff);
        pending_samples.push_back(16'h0001);

        // two entries: extremes swap places
        write_window_length(5'd2);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h7fff);
        pending_samples.push_back(16'h0005);

        // ties stay where they land
        write_window_length(5'd5);
        pending_samples.push_back(16'd7);
        pending_samples.push_back(16'd7);
        pending_samples.push_back(16'd7);
        pending_samples.push_back(-16'sd3);
        pending_samples.push_back(16'd7);
        pending_samples.push_back(16'h7fff);
        pending_samples.push_back(16'h8000);

        write_window_length(5'd9);
        push_random(40);

        // full window, with one pause mid-phase until everything is back
        write_window_length(5'd16);
        push_random(120);
        wait_drained();
        push_random(130);

        // above the maximum clamps to a full window
        write_window_length(5'd31);
        push_random(250);

        // shrinking keeps the count held, oldest still replaced
        write_window_length(5'd3);
        push_random(250);

        wait_drained();
        repeat (30) @(posedge clk);
        if (expected_medians.size() != 0)
            report_mismatch($sformatf("%0d words never returned", expected_medians.size()));
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/swm_pkg.sv
src/swm_store.sv
src/sliding_window_median.sv
tb/testbench.sv
